[rtl/psfpe_pkg.sv]
// Shared constants, codes and control types of the PSF pixel model evaluator.
package psfpe_pkg;

   localparam int PSF_SIDE    = 64;
   localparam int MAX_TERMS   = 32;
   localparam int PLANE_WORDS = PSF_SIDE * PSF_SIDE;
   localparam int STORE_WORDS = MAX_TERMS * PLANE_WORDS;
   localparam int ADDR_W      = $clog2(STORE_WORDS);
   localparam int TERM_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   localparam int POS_W   = 24;
   localparam int SCALE_W = 24;
   localparam int OFS_W   = 24;
   localparam int COEF_W  = 32;
   localparam int VAL_W   = 40;
   localparam int DIFF_W  = POS_W + 1;
   localparam int MUL_A_W = DIFF_W;
   localparam int MUL_B_W = COEF_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EVAL = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X    = 3'd0,
      REG_ORIGIN_Y    = 3'd1,
      REG_ORIGIN_Z    = 3'd2,
      REG_INV_SCALE_X = 3'd3,
      REG_INV_SCALE_Y = 3'd4,
      REG_INV_SCALE_Z = 3'd5,
      REG_XY_DEGREE   = 3'd6,
      REG_Z_DEGREE    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [POS_W-1:0]   origin_x;
      logic [POS_W-1:0]   origin_y;
      logic [POS_W-1:0]   origin_z;
      logic [SCALE_W-1:0] inv_scale_x;
      logic [SCALE_W-1:0] inv_scale_y;
      logic [SCALE_W-1:0] inv_scale_z;
      logic [2:0]         xy_degree;
      logic [1:0]         z_degree;
   } cfg_type;

   // Operand pair fed to the shared multiplier
   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_OFS_X,
      MUL_OFS_Y,
      MUL_OFS_Z,
      MUL_P1_P2,
      MUL_P1_DX,
      MUL_PXY_P3,
      MUL_WT_C,
      MUL_P2_DY,
      MUL_P3_DZ
   } mul_sel_type;

   // Destination of the registered product
   typedef enum logic [3:0] {
      WB_NONE,
      WB_DX,
      WB_DY,
      WB_DZ,
      WB_PXY,
      WB_P1,
      WB_WT,
      WB_ACC,
      WB_P2,
      WB_P3
   } wb_sel_type;

   typedef struct packed {
      mul_sel_type mul;
      wb_sel_type  wb;
      logic        init_p1;
      logic        init_p2;
      logic        plane_inc;
      logic        inc_i1;
      logic        inc_i2;
      logic        inc_i3;
      logic        finish;
   } ctrl_type;

   typedef struct packed {
      logic skip;
      logic i1_last;
      logic i2_last;
      logic i3_last;
   } status_type;

endpackage

[rtl/psf_polynomial_model_eval_core.sv]
// Top level: stream ports, configuration registers, coefficient store and result register.
//
// Load words (tuser cmd 0) write one coefficient into the store and are taken one per
// cycle while no evaluation runs. An evaluate word (cmd 1) runs a microcoded program on a
// single shared 25x32 multiplier: offset setup steps, then per z step N x-y terms, where
// N = (xy_degree+1)(xy_degree+2)/2 is the number of x-y terms; a term costs five steps of
// the multiplier loop. Degrees beyond the store's planes skip to the end with value 0 and
// the flag set. The next word is taken as soon as the program ends, while the result may
// still wait in the output register. The store is not cleared after reset; only entries
// that were loaded may be read.
module psf_polynomial_model_eval_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pix_x[5:0], pix_y[11:6], term[16:12], coeff[48:17], pos_x[72:49], pos_y[96:73],
   // pos_z[120:97], zero[127:121]
   input  logic [127:0] req_tdata,
   // cmd[0]
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // value[39:0]
   output logic [39:0]  rsp_tdata,
   // too_many_terms[0]
   output logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_data
);
   import psfpe_pkg::*;

   cfg_type                   cfg_ff;
   logic [COEF_W-1:0]         coeff_mem [STORE_WORDS];
   logic signed [COEF_W-1:0]  rd_data_ff;
   logic [ADDR_W-1:0]         pix_base_ff;
   logic                      rsp_valid_ff;
   logic signed [VAL_W-1:0]   rsp_value_ff;
   logic                      rsp_flag_ff;

   logic [5:0]                pix_x, pix_y;
   logic [4:0]                term;
   logic [COEF_W-1:0]         coeff_in;
   logic [POS_W-1:0]          pos_x, pos_y, pos_z;
   cmd_type                   cmd;
   logic                      req_accept, start, load_wr, pix_ok, term_ok, out_free, busy;
   logic [ADDR_W-1:0]         pix_off, wr_addr, rd_addr;
   logic [TERM_W-1:0]         plane;
   logic signed [VAL_W-1:0]   acc;
   logic                      too_many;
   ctrl_type                  ctrl;
   status_type                status;

   assign pix_x    = req_tdata[5:0];
   assign pix_y    = req_tdata[11:6];
   assign term     = req_tdata[16:12];
   assign coeff_in = req_tdata[48:17];
   assign pos_x    = req_tdata[72:49];
   assign pos_y    = req_tdata[96:73];
   assign pos_z    = req_tdata[120:97];
   assign cmd      = cmd_type'(req_tuser[0]);

   assign req_tready = !busy;
   assign req_accept = req_tvalid && req_tready;
   assign pix_ok     = (int'(pix_x) < PSF_SIDE) && (int'(pix_y) < PSF_SIDE);
   assign term_ok    = int'(term) < MAX_TERMS;
   assign start      = req_accept && (cmd == CMD_EVAL);
   // drop loads outside the model or the store
   assign load_wr    = req_accept && (cmd == CMD_LOAD) && pix_ok && term_ok;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign pix_off = ADDR_W'(pix_y) * ADDR_W'(PSF_SIDE) + ADDR_W'(pix_x);
   assign wr_addr = ADDR_W'(term) * ADDR_W'(PLANE_WORDS) + pix_off;
   assign rd_addr = ADDR_W'(plane) * ADDR_W'(PLANE_WORDS) + pix_base_ff;

   always_ff @(posedge clock) begin
      if (load_wr) begin
         coeff_mem[wr_addr] <= coeff_in;
      end
      rd_data_ff <= coeff_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pix_base_ff <= pix_off;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_ORIGIN_X:    cfg_ff.origin_x    <= csr_data;
            REG_ORIGIN_Y:    cfg_ff.origin_y    <= csr_data;
            REG_ORIGIN_Z:    cfg_ff.origin_z    <= csr_data;
            REG_INV_SCALE_X: cfg_ff.inv_scale_x <= csr_data;
            REG_INV_SCALE_Y: cfg_ff.inv_scale_y <= csr_data;
            REG_INV_SCALE_Z: cfg_ff.inv_scale_z <= csr_data;
            REG_XY_DEGREE:   cfg_ff.xy_degree   <= csr_data[2:0];
            REG_Z_DEGREE:    cfg_ff.z_degree    <= csr_data[1:0];
            default:         ;
         endcase
      end
   end

   psfpe_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .status   (status),
      .ctrl     (ctrl),
      .busy     (busy)
   );

   psfpe_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .pix_ok   (pix_ok),
      .cfg      (cfg_ff),
      .pos_x    (pos_x),
      .pos_y    (pos_y),
      .pos_z    (pos_z),
      .coeff    (rd_data_ff),
      .ctrl     (ctrl),
      .status   (status),
      .plane    (plane),
      .acc      (acc),
      .too_many (too_many)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         rsp_value_ff <= acc;
         rsp_flag_ff  <= too_many;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_value_ff;
   assign rsp_tuser[0] = rsp_flag_ff;

   a_finish_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish |-> out_free)
      else $error("result finished while the output register was still full");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy)
      else $error("evaluate word taken but the sequencer did not start");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      (ctrl.finish && too_many) |=> (rsp_tvalid && rsp_tdata == '0))
      else $error("too many terms but a non-zero value was delivered");

endmodule

[rtl/psfpe_seq.sv]
// Microcode sequencer: control ROM, step counter and conditional jumps.
module psfpe_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  out_free,
   input  psfpe_pkg::status_type status,
   output psfpe_pkg::ctrl_type   ctrl,
   output logic                  busy
);
   import psfpe_pkg::*;

   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_TERM  = PC_W'(4);
   localparam logic [PC_W-1:0] PC_INNER = PC_W'(5);
   localparam logic [PC_W-1:0] PC_DONE  = PC_W'(14);

   typedef enum logic [2:0] {
      BR_NEXT,
      BR_SKIP,
      BR_LOOP1,
      BR_LOOP2,
      BR_LOOP3,
      BR_FINISH
   } br_type;

   typedef struct packed {
      mul_sel_type     mul;
      wb_sel_type      wb;
      logic            init_p1;
      logic            init_p2;
      logic            plane_inc;
      br_type          br;
      logic [PC_W-1:0] target;
   } ucode_word_type;

   function automatic ucode_word_type rom_word(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      unique case (pc)
         4'd0:    w = '{MUL_OFS_X,  WB_NONE, 1'b0, 1'b0, 1'b0, BR_SKIP,   PC_DONE};
         4'd1:    w = '{MUL_OFS_Y,  WB_DX,   1'b0, 1'b0, 1'b0, BR_NEXT,   PC_DONE};
         4'd2:    w = '{MUL_OFS_Z,  WB_DY,   1'b0, 1'b0, 1'b0, BR_NEXT,   PC_DONE};
         4'd3:    w = '{MUL_NONE,   WB_DZ,   1'b0, 1'b0, 1'b0, BR_NEXT,   PC_DONE};
         4'd4:    w = '{MUL_P1_P2,  WB_NONE, 1'b0, 1'b0, 1'b0, BR_NEXT,   PC_DONE};
         4'd5:    w = '{MUL_P1_DX,  WB_PXY,  1'b0, 1'b0, 1'b0, BR_NEXT,   PC_DONE};
         4'd6:    w = '{MUL_PXY_P3, WB_P1,   1'b0, 1'b0, 1'b0, BR_NEXT,   PC_DONE};
         4'd7:    w = '{MUL_NONE,   WB_WT,   1'b0, 1'b0, 1'b0, BR_NEXT,   PC_DONE};
         4'd8:    w = '{MUL_WT_C,   WB_NONE, 1'b0, 1'b0, 1'b1, BR_NEXT,   PC_DONE};
         // accumulate, and start the next term's weight while looping
         4'd9:    w = '{MUL_P1_P2,  WB_ACC,  1'b0, 1'b0, 1'b0, BR_LOOP1,  PC_INNER};
         4'd10:   w = '{MUL_P2_DY,  WB_NONE, 1'b1, 1'b0, 1'b0, BR_NEXT,   PC_DONE};
         4'd11:   w = '{MUL_NONE,   WB_P2,   1'b0, 1'b0, 1'b0, BR_LOOP2,  PC_TERM};
         4'd12:   w = '{MUL_P3_DZ,  WB_NONE, 1'b0, 1'b1, 1'b0, BR_NEXT,   PC_DONE};
         4'd13:   w = '{MUL_NONE,   WB_P3,   1'b0, 1'b0, 1'b0, BR_LOOP3,  PC_TERM};
         default: w = '{MUL_NONE,   WB_NONE, 1'b0, 1'b0, 1'b0, BR_FINISH, PC_DONE};
      endcase
      return w;
   endfunction

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            run_ff, run_in;
   ucode_word_type  word;
   logic            jump;

   assign word = rom_word(pc_ff);
   assign busy = run_ff;

   // branch condition of the current step
   always_comb begin
      unique case (word.br)
         BR_NEXT:   jump = 1'b0;
         BR_SKIP:   jump = status.skip;
         BR_LOOP1:  jump = !status.i1_last;
         BR_LOOP2:  jump = !status.i2_last;
         BR_LOOP3:  jump = !status.i3_last;
         BR_FINISH: jump = out_free;
         default:   jump = 1'b0;
      endcase
   end

   always_comb begin
      pc_in  = pc_ff;
      run_in = run_ff;
      if (run_ff) begin
         if (word.br == BR_FINISH) begin
            if (jump) begin
               run_in = 1'b0;
            end
         end else if (jump) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + PC_W'(1);
         end
      end else if (start) begin
         pc_in  = '0;
         run_in = 1'b1;
      end
   end

   always_comb begin
      ctrl = '{MUL_NONE, WB_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
      if (run_ff) begin
         ctrl.mul       = word.mul;
         ctrl.wb        = word.wb;
         ctrl.init_p1   = word.init_p1;
         ctrl.init_p2   = word.init_p2;
         ctrl.plane_inc = word.plane_inc;
         ctrl.inc_i1    = (word.br == BR_LOOP1) && jump;
         ctrl.inc_i2    = (word.br == BR_LOOP2) && jump;
         ctrl.inc_i3    = (word.br == BR_LOOP3) && jump;
         ctrl.finish    = (word.br == BR_FINISH) && jump;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         run_ff <= 1'b0;
      end else begin
         pc_ff  <= pc_in;
         run_ff <= run_in;
      end
   end

endmodule

[rtl/psfpe_dp.sv]
// Datapath: offsets, powers, weights and accumulator around one shared multiplier.
module psfpe_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  pix_ok,
   input  psfpe_pkg::cfg_type                    cfg,
   input  logic [psfpe_pkg::POS_W-1:0]           pos_x,
   input  logic [psfpe_pkg::POS_W-1:0]           pos_y,
   input  logic [psfpe_pkg::POS_W-1:0]           pos_z,
   input  logic signed [psfpe_pkg::COEF_W-1:0]   coeff,
   input  psfpe_pkg::ctrl_type                   ctrl,
   output psfpe_pkg::status_type                 status,
   output logic [psfpe_pkg::TERM_W-1:0]          plane,
   output logic signed [psfpe_pkg::VAL_W-1:0]    acc,
   output logic                                  too_many
);
   import psfpe_pkg::*;

   localparam int WIDE_W  = PROD_W - 12;
   localparam int ASUM_W  = VAL_W + 1;
   localparam int NTERM_W = 9;

   localparam logic signed [OFS_W-1:0]  ONE_Q20 = OFS_W'(1 << 20);
   localparam logic signed [OFS_W-1:0]  OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};
   localparam logic signed [OFS_W-1:0]  OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0]  ACC_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic signed [VAL_W-1:0]  ACC_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [PROD_W-1:0] RND12   = PROD_W'(1 << 11);
   localparam logic signed [PROD_W-1:0] RND20   = PROD_W'(1 << 19);

   function automatic logic signed [OFS_W-1:0] sat_ofs(input logic signed [WIDE_W-1:0] v);
      logic signed [OFS_W-1:0] r;
      if (v > WIDE_W'(OFS_MAX)) begin
         r = OFS_MAX;
      end else if (v < WIDE_W'(OFS_MIN)) begin
         r = OFS_MIN;
      end else begin
         r = v[OFS_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat_acc(input logic signed [ASUM_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > ASUM_W'(ACC_MAX)) begin
         r = ACC_MAX;
      end else if (v < ASUM_W'(ACC_MIN)) begin
         r = ACC_MIN;
      end else begin
         r = v[VAL_W-1:0];
      end
      return r;
   endfunction

   logic signed [DIFF_W-1:0]  diff_x_ff, diff_y_ff, diff_z_ff;
   logic signed [OFS_W-1:0]   dx_ff, dy_ff, dz_ff;
   logic signed [OFS_W-1:0]   p1_ff, p2_ff, p3_ff, pxy_ff, wt_ff;
   logic signed [VAL_W-1:0]   acc_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [2:0]                i1_ff, i2_ff;
   logic [1:0]                i3_ff;
   logic [TERM_W-1:0]         plane_ff;
   logic                      skip_ff, too_many_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [PROD_W-1:0]  shr12, shr20;
   logic signed [OFS_W-1:0]   ofs_val, q20_val;
   logic signed [ASUM_W-1:0]  acc_sum;
   logic signed [VAL_W-1:0]   acc_val;
   logic [NTERM_W-1:0]        nterms;
   logic                      too_many_now;

   // planes needed by the configured degrees
   assign nterms = ((NTERM_W'(cfg.z_degree) + NTERM_W'(1))
                  * (NTERM_W'(cfg.xy_degree) + NTERM_W'(1))
                  * (NTERM_W'(cfg.xy_degree) + NTERM_W'(2))) >> 1;
   assign too_many_now = int'(nterms) > MAX_TERMS;

   always_comb begin
      unique case (ctrl.mul)
         MUL_OFS_X:  begin mul_a = diff_x_ff;        mul_b = MUL_B_W'(cfg.inv_scale_x); end
         MUL_OFS_Y:  begin mul_a = diff_y_ff;        mul_b = MUL_B_W'(cfg.inv_scale_y); end
         MUL_OFS_Z:  begin mul_a = diff_z_ff;        mul_b = MUL_B_W'(cfg.inv_scale_z); end
         MUL_P1_P2:  begin mul_a = MUL_A_W'(p1_ff);  mul_b = MUL_B_W'(p2_ff); end
         MUL_P1_DX:  begin mul_a = MUL_A_W'(p1_ff);  mul_b = MUL_B_W'(dx_ff); end
         MUL_PXY_P3: begin mul_a = MUL_A_W'(pxy_ff); mul_b = MUL_B_W'(p3_ff); end
         MUL_WT_C:   begin mul_a = MUL_A_W'(wt_ff);  mul_b = coeff; end
         MUL_P2_DY:  begin mul_a = MUL_A_W'(p2_ff);  mul_b = MUL_B_W'(dy_ff); end
         MUL_P3_DZ:  begin mul_a = MUL_A_W'(p3_ff);  mul_b = MUL_B_W'(dz_ff); end
         default:    begin mul_a = '0;               mul_b = '0; end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // round half up and saturate the registered product
   assign shr12   = (prod_ff + RND12) >>> 12;
   assign shr20   = (prod_ff + RND20) >>> 20;
   assign ofs_val = sat_ofs(shr12[WIDE_W-1:0]);
   assign q20_val = sat_ofs(shr20[WIDE_W-1:0]);
   assign acc_sum = ASUM_W'(acc_ff) + shr20[ASUM_W-1:0];
   assign acc_val = sat_acc(acc_sum);

   always_ff @(posedge clock) begin
      if (ctrl.mul != MUL_NONE) begin
         prod_ff <= prod_in;
      end
      if (start) begin
         diff_x_ff <= signed'({1'b0, pos_x}) - signed'({1'b0, cfg.origin_x});
         diff_y_ff <= signed'({1'b0, pos_y}) - signed'({1'b0, cfg.origin_y});
         diff_z_ff <= signed'({1'b0, pos_z}) - signed'({1'b0, cfg.origin_z});
         p1_ff     <= ONE_Q20;
         p2_ff     <= ONE_Q20;
         p3_ff     <= ONE_Q20;
         acc_ff    <= '0;
      end else begin
         unique case (ctrl.wb)
            WB_DX:   dx_ff  <= ofs_val;
            WB_DY:   dy_ff  <= ofs_val;
            WB_DZ:   dz_ff  <= ofs_val;
            WB_PXY:  pxy_ff <= q20_val;
            WB_P1:   p1_ff  <= q20_val;
            WB_WT:   wt_ff  <= q20_val;
            WB_ACC:  acc_ff <= acc_val;
            WB_P2:   p2_ff  <= q20_val;
            WB_P3:   p3_ff  <= q20_val;
            default: ;
         endcase
         if (ctrl.init_p1) begin
            p1_ff <= ONE_Q20;
         end
         if (ctrl.init_p2) begin
            p2_ff <= ONE_Q20;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i1_ff       <= '0;
         i2_ff       <= '0;
         i3_ff       <= '0;
         plane_ff    <= '0;
         skip_ff     <= 1'b0;
         too_many_ff <= 1'b0;
      end else if (start) begin
         i1_ff       <= '0;
         i2_ff       <= '0;
         i3_ff       <= '0;
         plane_ff    <= '0;
         skip_ff     <= too_many_now || !pix_ok;
         too_many_ff <= too_many_now;
      end else begin
         if (ctrl.inc_i1) begin
            i1_ff <= i1_ff + 3'd1;
         end else if (ctrl.init_p1) begin
            i1_ff <= '0;
         end
         if (ctrl.inc_i2) begin
            i2_ff <= i2_ff + 3'd1;
         end else if (ctrl.init_p2) begin
            i2_ff <= '0;
         end
         if (ctrl.inc_i3) begin
            i3_ff <= i3_ff + 2'd1;
         end
         if (ctrl.plane_inc) begin
            plane_ff <= plane_ff + TERM_W'(1);
         end
      end
   end

   assign status.skip    = skip_ff;
   assign status.i1_last = ({1'b0, i1_ff} + {1'b0, i2_ff}) == {1'b0, cfg.xy_degree};
   assign status.i2_last = i2_ff == cfg.xy_degree;
   assign status.i3_last = i3_ff == cfg.z_degree;
   assign plane          = plane_ff;
   assign acc            = acc_ff;
   assign too_many       = too_many_ff;

endmodule

[bench/psf_value_checker.sv]
// Checker for the PSF pixel model evaluator: snoops the channels, predicts results, compares.
module psf_value_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   // pix_x[5:0], pix_y[11:6], term[16:12], coeff[48:17], pos_x[72:49], pos_y[96:73],
   // pos_z[120:97], zero[127:121]
   input  logic [127:0] req_tdata,
   // cmd[0]
   input  logic [0:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   // value[39:0]
   input  logic [39:0]  rsp_tdata,
   // too_many_terms[0]
   input  logic [0:0]   rsp_tuser,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_data,
   output int           mismatches,
   output int           values_owed
);
   import psfpe_pkg::*;

   localparam longint ONE_Q20 = 64'sd1048576;
   localparam longint OFS_HI  = 64'sd8388607;
   localparam longint OFS_LO  = -64'sd8388608;
   localparam longint ACC_HI  = 64'sd549755813887;
   localparam longint ACC_LO  = -64'sd549755813888;

   typedef struct packed {
      logic [39:0] value;
      logic        too_many;
   } pixel_result_type;

   cfg_type          cfg;
   logic [31:0]      coef_mem [0:STORE_WORDS-1];
   pixel_result_type owed_pixels [$];
   int               fail_count = 0;
   int               owed_count = 0;

   assign mismatches  = fail_count;
   assign values_owed = owed_count;

   // floor division by 2^s after adding half an LSB
   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint q20_offset(input logic [23:0] pos, input logic [23:0] org,
                                         input logic [23:0] inv);
      longint d;
      d = longint'(pos) - longint'(org);
      return clip(round_shift(d * longint'(inv), 12), OFS_LO, OFS_HI);
   endfunction

   function automatic longint q20_mul(input longint a, input longint b);
      return clip(round_shift(a * b, 20), OFS_LO, OFS_HI);
   endfunction

   function automatic pixel_result_type model_pixel_value(input logic [11:0] pix,
                                                          input logic [23:0] pos_x,
                                                          input logic [23:0] pos_y,
                                                          input logic [23:0] pos_z);
      pixel_result_type r;
      longint dx, dy, dz, p1, p2, p3, wt, c, acc;
      int xd, zd, plane;
      xd = int'(cfg.xy_degree);
      zd = int'(cfg.z_degree);
      r.too_many = ((zd + 1) * (xd + 1) * (xd + 2) / 2) > MAX_TERMS;
      acc = 0;
      if (!r.too_many) begin
         dx = q20_offset(pos_x, cfg.origin_x, cfg.inv_scale_x);
         dy = q20_offset(pos_y, cfg.origin_y, cfg.inv_scale_y);
         dz = q20_offset(pos_z, cfg.origin_z, cfg.inv_scale_z);
         plane = 0;
         p3 = ONE_Q20;
         // z outermost, then y, then x; each term reads the next plane
         for (int i3 = 0; i3 <= zd; i3++) begin
            p2 = ONE_Q20;
            for (int i2 = 0; i2 <= xd; i2++) begin
               p1 = ONE_Q20;
               for (int i1 = 0; i1 + i2 <= xd; i1++) begin
                  c   = longint'($signed(coef_mem[plane * PLANE_WORDS + int'(pix)]));
                  wt  = q20_mul(q20_mul(p1, p2), p3);
                  acc = clip(acc + round_shift(wt * c, 20), ACC_LO, ACC_HI);
                  p1  = q20_mul(p1, dx);
                  plane++;
               end
               p2 = q20_mul(p2, dy);
            end
            p3 = q20_mul(p3, dz);
         end
      end
      r.value = acc[39:0];
      return r;
   endfunction

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         cfg = '0;
         owed_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_ORIGIN_X:    cfg.origin_x    = csr_data;
               REG_ORIGIN_Y:    cfg.origin_y    = csr_data;
               REG_ORIGIN_Z:    cfg.origin_z    = csr_data;
               REG_INV_SCALE_X: cfg.inv_scale_x = csr_data;
               REG_INV_SCALE_Y: cfg.inv_scale_y = csr_data;
               REG_INV_SCALE_Z: cfg.inv_scale_z = csr_data;
               REG_XY_DEGREE:   cfg.xy_degree   = csr_data[2:0];
               REG_Z_DEGREE:    cfg.z_degree    = csr_data[1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (cmd_type'(req_tuser[0]) == CMD_LOAD)
               coef_mem[{req_tdata[16:12], req_tdata[11:0]}] = req_tdata[48:17];
            else
               owed_pixels.push_back(model_pixel_value(req_tdata[11:0], req_tdata[72:49],
                                                       req_tdata[96:73], req_tdata[120:97]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (owed_pixels.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word: value %h too_many_terms %b",
                           rsp_tdata, rsp_tuser[0]);
            end else begin
               want = owed_pixels.pop_front();
               if (want.value !== rsp_tdata || want.too_many !== rsp_tuser[0]) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result mismatch: value exp %h got %h, too_many_terms exp %b got %b",
                              want.value, rsp_tdata, want.too_many, rsp_tuser[0]);
               end
            end
         end
      end
      owed_count = owed_pixels.size();
   end

endmodule

[bench/testbench.sv]
// Top of the bench: clock, reset, stimulus for the PSF pixel model evaluator and the verdict.
module testbench;
   import psfpe_pkg::*;

   localparam int HALF_PERIOD = 2;
   localparam int RESET_CYCLES = 7;
   localparam int SETTLE = 200;
   localparam int IDLE_LIMIT = 4000;
   localparam int PHASES = 12;
   localparam int PHASE_WORDS = 160;
   localparam int POS_TOP = 16777215;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [23:0]  csr_data = '0;
   int           mismatches;
   int           values_owed;

   cfg_type      setting = '0;
   bit           loaded [0:STORE_WORDS-1];
   logic [11:0]  pool [0:15];
   bit           quiet = 1'b0;
   int           words_sent = 0;
   int           hold_left = 0;
   int           idle_cycles = 0;

   psf_polynomial_model_eval_core dut (.*);

   psf_value_checker u_check (.*);

   always #HALF_PERIOD clock = ~clock;

   // result side: ready runs, broken by stall bursts unless the phase is quiet
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
         rsp_tready <= 1'b1;
         hold_left  <= $urandom_range(0, 30);
      end else begin
         rsp_tready <= 1'b0;
         hold_left  <= $urandom_range(0, 16);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0100_0000 + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
         default: return $urandom;
      endcase
   endfunction

   // mostly near the origin so that offsets stay in range, sometimes anywhere
   function automatic logic [23:0] rand_pos(input logic [23:0] org);
      int v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = POS_TOP;
         2, 3: v = $urandom_range(0, POS_TOP);
         default: v = int'(org) + int'($urandom_range(0, 262144)) - 131072;
      endcase
      if (v < 0) v = 0;
      if (v > POS_TOP) v = POS_TOP;
      return v[23:0];
   endfunction

   function automatic logic [23:0] rand_scale();
      case ($urandom_range(0, 11))
         0: return 24'd0;
         1: return 24'hFF_FFFF;
         2: return 24'($urandom_range(0, POS_TOP));
         3, 4: return 24'($urandom_range(0, 1 << 20));
         default: return 24'($urandom_range(0, 1 << 17));
      endcase
   endfunction

   function automatic cfg_type random_setting();
      cfg_type s;
      s.origin_x    = 24'($urandom_range(0, POS_TOP));
      s.origin_y    = 24'($urandom_range(0, POS_TOP));
      s.origin_z    = 24'($urandom_range(0, POS_TOP));
      s.inv_scale_x = rand_scale();
      s.inv_scale_y = rand_scale();
      s.inv_scale_z = rand_scale();
      s.xy_degree   = 3'($urandom_range(0, 6));
      s.z_degree    = 2'($urandom_range(0, 3));
      return s;
   endfunction

   function automatic logic [11:0] pick_pixel();
      if ($urandom_range(0, 7) == 0)
         return 12'($urandom_range(0, 4095));
      return pool[$urandom_range(0, 15)];
   endfunction

   // valid stays high from one word to the next unless a gap is drawn
   task automatic send_word(input cmd_type c, input logic [4:0] plane, input logic [31:0] coeff,
                            input logic [11:0] pix, input logic [23:0] px,
                            input logic [23:0] py, input logic [23:0] pz);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= {7'd0, pz, py, px, coeff, plane, pix};
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic load_coef(input logic [11:0] pix, input logic [4:0] plane,
                            input logic [31:0] coeff);
      loaded[{plane, pix}] = 1'b1;
      send_word(CMD_LOAD, plane, coeff, pix, 24'($urandom), 24'($urandom), 24'($urandom));
   endtask

   // fill any plane this pixel still lacks before evaluating it
   task automatic evaluate(input logic [11:0] pix);
      int n;
      n = (int'(setting.z_degree) + 1) * (int'(setting.xy_degree) + 1) *
          (int'(setting.xy_degree) + 2) / 2;
      if (n > MAX_TERMS) n = 0;
      for (int p = 0; p < n; p++)
         if (!loaded[{p[4:0], pix}]) load_coef(pix, p[4:0], rand_coef());
      send_word(CMD_EVAL, 5'($urandom_range(0, 31)), $urandom, pix,
                rand_pos(setting.origin_x), rand_pos(setting.origin_y),
                rand_pos(setting.origin_z));
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [23:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(input cfg_type s);
      setting = s;
      write_reg(REG_ORIGIN_X, s.origin_x);
      write_reg(REG_ORIGIN_Y, s.origin_y);
      write_reg(REG_ORIGIN_Z, s.origin_z);
      write_reg(REG_INV_SCALE_X, s.inv_scale_x);
      write_reg(REG_INV_SCALE_Y, s.inv_scale_y);
      write_reg(REG_INV_SCALE_Z, s.inv_scale_z);
      write_reg(REG_XY_DEGREE, {21'd0, s.xy_degree});
      write_reg(REG_Z_DEGREE, {22'd0, s.z_degree});
   endtask

   // stop sending and hold off until every result is in, then let the bench settle
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (values_owed != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   initial begin
      cfg_type s;
      int      target;
      pool[0] = 12'h000;
      pool[1] = 12'h03F;
      pool[2] = 12'hFC0;
      pool[3] = 12'hFFF;
      for (int i = 4; i < 16; i++) pool[i] = 12'($urandom_range(0, 4095));
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at reset: zero scales, single term, so the value is the coefficient
      load_coef(12'h000, 5'd0, 32'h7FFF_FFFF);
      send_word(CMD_EVAL, 5'd0, 32'd0, 12'h000, 24'd0, 24'd0, 24'd0);
      load_coef(12'hFFF, 5'd0, 32'h8000_0000);
      send_word(CMD_EVAL, 5'd31, 32'hFFFF_FFFF, 12'hFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                24'hFF_FFFF);
      load_coef(12'hFC0, 5'd31, 32'hFFFF_FFFF);
      load_coef(12'hFC0, 5'd0, 32'h0000_0001);
      send_word(CMD_EVAL, 5'd0, 32'd0, 12'hFC0, 24'h00_0001, 24'h80_0000, 24'h7F_FFFF);
      load_coef(12'h03F, 5'd0, 32'h0100_0000);
      load_coef(12'h03F, 5'd0, 32'hFF00_0000);
      evaluate(12'h03F);
      evaluate(12'h000);
      evaluate(12'hFFF);

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         s = random_setting();
         case (ph)
            0: begin
               s.xy_degree = 3'd6;
               s.z_degree  = 2'd0;
            end
            1: begin
               s.xy_degree = 3'd0;
               s.z_degree  = 2'd3;
            end
            2: begin
               s.xy_degree = 3'd6;
               s.z_degree  = 2'd3;
            end
            3: begin
               s.origin_x    = 24'hFF_FFFF;
               s.origin_y    = 24'hFF_FFFF;
               s.origin_z    = 24'hFF_FFFF;
               s.inv_scale_x = 24'hFF_FFFF;
               s.inv_scale_y = 24'hFF_FFFF;
               s.inv_scale_z = 24'hFF_FFFF;
               s.xy_degree   = 3'd2;
               s.z_degree    = 2'd3;
            end
            4: begin
               s.origin_x    = 24'd0;
               s.origin_y    = 24'd0;
               s.origin_z    = 24'd0;
               s.inv_scale_x = 24'hFF_FFFF;
               s.inv_scale_y = 24'hFF_FFFF;
               s.inv_scale_z = 24'hFF_FFFF;
               s.xy_degree   = 3'd4;
               s.z_degree    = 2'd1;
            end
            5: begin
               s.inv_scale_x = 24'd0;
               s.inv_scale_y = 24'd0;
               s.inv_scale_z = 24'd0;
               s.xy_degree   = 3'd3;
               s.z_degree    = 2'd2;
            end
            default: ;
         endcase
         apply_setting(s);
         quiet  = (ph == PHASES - 1) || ($urandom_range(0, 4) == 0);
         target = words_sent + PHASE_WORDS;
         while (words_sent < target) begin
            if ($urandom_range(0, 99) < 20)
               load_coef(pick_pixel(), 5'($urandom_range(0, 31)), rand_coef());
            else
               evaluate(pick_pixel());
         end
      end
      drain();

      if (mismatches == 0 && values_owed == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
